/* src/sqpl_pkg.sv */
// Package for the submission queue publish ledger.
// Holds request and resolution codes and shared types; depends on nothing.
package sqpl_pkg;

  typedef enum logic [1:0] {
    REQ_RESERVE  = 2'd0,
    REQ_HEAD     = 2'd1,
    REQ_COMPLETE = 2'd2,
    REQ_RESOLVE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    RES_COMMIT   = 2'd0,
    RES_ROLLBACK = 2'd1,
    RES_FATAL    = 2'd2
  } resolution_e;

  localparam logic [1:0] AXI_OKAY = 2'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] request_id;
    logic        batch_last;
    logic [31:0] seq_value;
    logic [1:0]  axi_resp;
    logic        no_side_effect;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        accepted;
    logic [31:0] slot_sequence;
    logic [1:0]  resolution;
  } rsp_t;

  // Scan unit control and status
  typedef struct packed {
    logic        start;
    logic [31:0] id;
  } scan_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } scan_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_COPY = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

endpackage

/* src/sqpl_if.sv */
// Valid/ready channel interface for the publish ledger.
// Payload type comes in as a type parameter.
interface sqpl_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/sqpl_scan.sv */
// Shared compare unit: scans issued IDs then staged IDs, one entry a cycle.
// Depends on sqpl_pkg.
module sqpl_scan #(
  parameter int unsigned IdCapacity = 64,
  parameter int unsigned MaxBatch   = 16,
  localparam int unsigned IW = $clog2(IdCapacity + 1),
  localparam int unsigned BW = $clog2(MaxBatch + 1),
  localparam int unsigned TW = $clog2(IdCapacity + MaxBatch + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sqpl_pkg::scan_cmd_t  cmd_i,
  input  logic [IW-1:0]        issued_count_i,
  input  logic [BW-1:0]        batch_count_i,
  output logic [TW-1:0]        rd_idx_o,
  input  logic [31:0]          rd_data_i,
  output sqpl_pkg::scan_sts_t  sts_o
);
  import sqpl_pkg::*;

  logic [TW-1:0] idx_q, idx_d, lim;
  logic          busy_q, busy_d, chk_q, chk_d, hit_q, hit_d, done_q, done_d;
  logic [31:0]   id_q, id_d;

  // Read address walks issued range, then staged range at offset
  assign lim = TW'(issued_count_i) + TW'(batch_count_i);

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    chk_d  = 1'b0;
    hit_d  = hit_q;
    done_d = 1'b0;
    id_d   = id_q;
    if (cmd_i.start) begin
      idx_d  = '0;
      busy_d = 1'b1;
      hit_d  = 1'b0;
      id_d   = cmd_i.id;
    end else if (busy_q) begin
      if (chk_q && rd_data_i == id_q) hit_d = 1'b1;
      if (idx_q < lim) begin
        chk_d = 1'b1;
        idx_d = idx_q + 1'b1;
      end else if (!chk_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Map linear index onto the two stores
  always_comb begin
    if (idx_q < TW'(issued_count_i)) rd_idx_o = idx_q;
    else rd_idx_o = TW'(IdCapacity) + (idx_q - TW'(issued_count_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; busy_q <= 1'b0; chk_q <= 1'b0; hit_q <= 1'b0; done_q <= 1'b0;
    end else begin
      idx_q <= idx_d; busy_q <= busy_d; chk_q <= chk_d; hit_q <= hit_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) id_q <= id_d;

  assign sts_o = '{busy: busy_q, done: done_q, hit: hit_q};
endmodule

/* src/submission_queue_publish_ledger.sv */
// Publish ledger for a submission ring. One word in at a time. A reserve word
// has the shared compare unit walk the ID memory one entry per cycle, checking
// whether its ID is already among the issued and staged IDs. A closing reserve
// word then forms the result; an accepted batch then copies each batch ID into
// the issued list. Observe and resolve words skip the compare pass. The result
// sits in an output register; the next word is taken once it has been handed
// off. Data from unwritten ID entries is never used.
module submission_queue_publish_ledger #(
  parameter int unsigned ID_CAPACITY = 64,
  parameter int unsigned MAX_BATCH   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  sqpl_if.sink        req,
  sqpl_if.source      rsp
);
  import sqpl_pkg::*;

  localparam int unsigned IW = $clog2(ID_CAPACITY + 1);
  localparam int unsigned BW = $clog2(MAX_BATCH + 1);
  localparam int unsigned TW = $clog2(ID_CAPACITY + MAX_BATCH + 1);
  localparam int unsigned DEPTH = ID_CAPACITY + MAX_BATCH;

  state_e state_q, state_d;
  logic [31:0] depth_q, comm_q, tent_q, ohead_q, reuse_q, pbase_q, ptail_q;
  logic [31:0] comm_d, tent_d, ohead_d, reuse_d, pbase_d, ptail_d;
  logic pend_q, pend_d, hev_q, hev_d, cev_q, cev_d, bad_q, bad_d;
  logic [IW-1:0] icnt_q, icnt_d;
  logic [BW-1:0] bcnt_q, bcnt_d, cp_q, cp_d;
  req_t  cur_q, cur_d;
  rsp_t  out_q, out_d;
  logic  ovld_q, ovld_d;

  logic [31:0]   mem [DEPTH];
  logic [TW-1:0] scan_idx, rd_addr, wr_addr;
  logic [31:0]   rd_q;
  logic          we;
  logic [31:0]   wdata;
  scan_cmd_t     cmd;
  scan_sts_t     sts;

  // Memory: issued IDs below ID_CAPACITY, staged IDs above
  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wdata;
    rd_q <= mem[rd_addr];
  end

  sqpl_scan #(.IdCapacity(ID_CAPACITY), .MaxBatch(MAX_BATCH)) u_scan (
    .clk_i, .rst_ni, .cmd_i(cmd), .issued_count_i(icnt_q),
    .batch_count_i(bcnt_q), .rd_idx_o(scan_idx), .rd_data_i(rd_q), .sts_o(sts)
  );

  logic [32:0] occ, free_ring, nxt;
  logic [IW:0] free_ids;
  logic        bad_now, ok;
  logic [31:0] min_h;

  assign req.ready = (state_q == ST_IDLE) && !ovld_q;
  assign rsp.valid = ovld_q;
  assign rsp.data  = out_q;

  always_comb begin
    occ       = {1'b0, comm_q - reuse_q};
    free_ring = (occ > {1'b0, depth_q}) ? '0 : {1'b0, depth_q} - occ;
    free_ids  = (IW + 1)'(ID_CAPACITY) - {1'b0, icnt_q};
    nxt       = {1'b0, comm_q} + 33'(bcnt_q);
  end

  always_comb begin
    state_d = state_q; comm_d = comm_q; tent_d = tent_q; ohead_d = ohead_q;
    reuse_d = reuse_q; pbase_d = pbase_q; ptail_d = ptail_q; pend_d = pend_q;
    hev_d = hev_q; cev_d = cev_q; bad_d = bad_q; icnt_d = icnt_q; bcnt_d = bcnt_q;
    cp_d = cp_q; cur_d = cur_q; out_d = out_q; ovld_d = ovld_q;
    cmd = '{start: 1'b0, id: cur_q.request_id};
    rd_addr = scan_idx; we = 1'b0; wr_addr = '0; wdata = '0;
    bad_now = 1'b0; ok = 1'b0; min_h = '0;
    if (ovld_q && rsp.ready) ovld_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          cur_d = req.data;
          if (req_type_e'(req.data.req_type) == REQ_RESERVE) begin
            cmd.start = 1'b1;
            cmd.id    = req.data.request_id;
            state_d   = ST_SCAN;
          end else state_d = ST_OUT;
        end
      end
      ST_SCAN: begin
        // Stage the ID once the compare pass is done
        if (sts.done) begin
          bad_now = bad_q || sts.hit || cur_q.request_id == '0;
          if (bcnt_q < BW'(MAX_BATCH)) begin
            we = 1'b1; wr_addr = TW'(ID_CAPACITY) + TW'(bcnt_q);
            wdata = cur_q.request_id; bcnt_d = bcnt_q + 1'b1;
          end else bad_now = 1'b1;
          bad_d = bad_now;
          if (!cur_q.batch_last) state_d = ST_IDLE;
          else state_d = ST_OUT;
        end
      end
      ST_COPY: begin
        // Move one staged ID to the issued list per cycle
        if (cp_q != bcnt_q) rd_addr = TW'(ID_CAPACITY) + TW'(cp_q);
        if (cp_q != '0) begin
          we = 1'b1; wr_addr = TW'(icnt_q); wdata = rd_q; icnt_d = icnt_q + 1'b1;
        end
        if (cp_q == bcnt_q) begin
          bcnt_d = '0; state_d = ST_IDLE;
        end else cp_d = cp_q + 1'b1;
      end
      ST_OUT: begin
        out_d = '{result_kind: cur_q.req_type, accepted: 1'b0, slot_sequence: '0,
                  resolution: RES_COMMIT};
        ovld_d = 1'b1; state_d = ST_IDLE;
        case (req_type_e'(cur_q.req_type))
          REQ_RESERVE: begin
            ok = !bad_q && !pend_q && bcnt_q != '0 && (IW + 1)'(bcnt_q) <= free_ids
                 && 33'(bcnt_q) <= free_ring && !nxt[32];
            bad_d = 1'b0;
            if (ok) begin
              out_d.accepted = 1'b1; out_d.slot_sequence = comm_q;
              tent_d = nxt[31:0]; ptail_d = nxt[31:0]; pbase_d = comm_q;
              pend_d = 1'b1; hev_d = 1'b0; cev_d = 1'b0;
              cp_d = '0; state_d = ST_COPY;
            end else bcnt_d = '0;
          end
          REQ_HEAD: begin
            if (!(cur_q.seq_value < ohead_q || tent_q < cur_q.seq_value)) begin
              ohead_d = cur_q.seq_value;
              if (pend_q && pbase_q < cur_q.seq_value) hev_d = 1'b1;
              reuse_d = (cur_q.seq_value < comm_q) ? cur_q.seq_value : comm_q;
              out_d.accepted = 1'b1;
            end
          end
          REQ_COMPLETE: begin
            if (pend_q && cur_q.seq_value >= pbase_q && cur_q.seq_value < ptail_q) begin
              cev_d = 1'b1; out_d.accepted = 1'b1;
            end
          end
          default: begin
            out_d.resolution = RES_FATAL;
            if (pend_q) begin
              if (cur_q.axi_resp == AXI_OKAY) begin
                comm_d = ptail_q; tent_d = ptail_q; pend_d = 1'b0;
                min_h = (ohead_q < ptail_q) ? ohead_q : ptail_q;
                reuse_d = min_h; out_d.resolution = RES_COMMIT;
              end else if (cur_q.no_side_effect && !hev_q && !cev_q) begin
                tent_d = pbase_q; pend_d = 1'b0;
                reuse_d = (ohead_q < comm_q) ? ohead_q : comm_q;
                out_d.resolution = RES_ROLLBACK;
              end
            end
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; depth_q <= 32'd256; comm_q <= '0; tent_q <= '0;
      ohead_q <= '0; reuse_q <= '0; pbase_q <= '0; ptail_q <= '0; pend_q <= 1'b0;
      hev_q <= 1'b0; cev_q <= 1'b0; bad_q <= 1'b0; icnt_q <= '0; bcnt_q <= '0;
      cp_q <= '0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; comm_q <= comm_d; tent_q <= tent_d; ohead_q <= ohead_d;
      reuse_q <= reuse_d; pbase_q <= pbase_d; ptail_q <= ptail_d; pend_q <= pend_d;
      hev_q <= hev_d; cev_q <= cev_d; bad_q <= bad_d; icnt_q <= icnt_d;
      bcnt_q <= bcnt_d; cp_q <= cp_d; ovld_q <= ovld_d;
      if (cfg_we_i) depth_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end
endmodule

/* src/sqpl_checker.sv */
// Port-level checker for the publish ledger, bound to the top level.
// Depends on sqpl_pkg.
module sqpl_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input sqpl_pkg::rsp_t  rsp_data
);
  import sqpl_pkg::*;

  // Held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
  // No new word while a result waits
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("ready with pending result");
  // Resolve never reports accepted
  a_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.result_kind == REQ_RESOLVE |-> !rsp_data.accepted)
    else $error("resolve accepted");
  // Slot only on accepted reserve
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_data.accepted |-> rsp_data.slot_sequence == '0)
    else $error("slot without accept");
  // Resolution code in range
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_data.resolution != 2'd3) else $error("bad resolution");
endmodule

bind submission_queue_publish_ledger sqpl_checker u_chk (
  .clk_i, .rst_ni, .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
